// ----- src/assert_macros.svh -----
// ============================================================================
// assert_macros.svh
// Assertion macros used by the checker module.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under the synchronous reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// next-cycle implication under the synchronous reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ----- src/bfes_pkg.sv -----
// ============================================================================
// bfes_pkg
// Types and constants of the bitmap free extent scanner.
// ============================================================================
package bfes_pkg;

  localparam int BLOCK_BITS = 32;
  localparam int IDX_W      = BLOCK_BITS - 3;
  localparam int BLK_W      = 32;
  localparam int SIZE_W     = 21;
  localparam int PROD_W     = 53;
  localparam int OFS_W      = 52;
  localparam int MAX_EVT    = 6;
  localparam int EVT_IW     = 3;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

  typedef enum logic {
    CFG_BLOCK_COUNT = 1'b0,
    CFG_BLOCK_SIZE  = 1'b1
  } cfg_idx_t;

  // run close or summary found while scanning one byte
  typedef struct packed {
    logic             summ;
    logic [BLK_W-1:0] start;
    logic [BLK_W-1:0] stop;
  } evt_t;

  // queue entry: start carries the free block total on a summary
  typedef struct packed {
    logic             summ;
    logic [BLK_W-1:0] start;
    logic [BLK_W-1:0] stop;
    logic [BLK_W-1:0] len;
    logic             last;
  } qent_t;

endpackage

// ----- src/bfes_front.sv -----
// ============================================================================
// bfes_front
// Accepts bitmap bytes, tracks the open run and lists the run closes and the
// summary each byte causes, then pushes them one per cycle unless q_full.
// ============================================================================
module bfes_front import bfes_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [BLK_W-1:0] block_count,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_bitmap_byte,
  input  logic             in_final_byte,
  output logic             q_push,
  output qent_t            q_wdata,
  input  logic             q_full
);

  logic [IDX_W-1:0]  byte_index_r, byte_index_nxt;
  logic              run_open_r, run_open_nxt;
  logic [BLK_W-1:0]  open_start_r, open_start_nxt;
  logic [BLK_W-1:0]  free_total_r, free_total_nxt;
  evt_t              evts_r [MAX_EVT];
  evt_t              evts   [MAX_EVT];
  logic [EVT_IW-1:0] cnt_r, ptr_r, evt_cnt;

  logic [BLK_W-1:0]  base, blk, stop_fin, stop_c;
  logic [BLK_W:0]    end_wide;
  logic [3:0]        free_cnt;
  logic              busy, last_push, accept, at_last;
  evt_t              sel;

  always_comb begin
    base           = BLK_W'({byte_index_r, 3'b000});
    run_open_nxt   = run_open_r;
    open_start_nxt = open_start_r;
    free_cnt       = '0;
    evt_cnt        = '0;
    blk            = base;
    for (int j = 0; j < MAX_EVT; j++) begin
      evts[j] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      blk = base | BLK_W'(i);
      if (blk < block_count) begin
        if (!in_bitmap_byte[7-i]) begin
          if (!run_open_nxt) begin
            run_open_nxt   = 1'b1;
            open_start_nxt = blk;
          end
          free_cnt = free_cnt + 1'b1;
        end else if (run_open_nxt) begin
          evts[evt_cnt] = '{summ: 1'b0, start: open_start_nxt, stop: blk};
          evt_cnt       = evt_cnt + 1'b1;
          run_open_nxt  = 1'b0;
        end
      end
    end
    free_total_nxt = free_total_r + BLK_W'(free_cnt);
    end_wide = {1'b0, base} + (BLK_W+1)'(8);
    stop_fin = (end_wide > {1'b0, block_count}) ? block_count : end_wide[BLK_W-1:0];
    byte_index_nxt = byte_index_r + 1'b1;
    if (in_final_byte) begin
      if (run_open_nxt) begin
        evts[evt_cnt] = '{summ: 1'b0, start: open_start_nxt, stop: stop_fin};
        evt_cnt       = evt_cnt + 1'b1;
      end
      evts[evt_cnt]  = '{summ: 1'b1, start: free_total_nxt, stop: '0};
      evt_cnt        = evt_cnt + 1'b1;
      run_open_nxt   = 1'b0;
      open_start_nxt = '0;
      free_total_nxt = '0;
      byte_index_nxt = '0;
    end
  end

  assign busy      = (cnt_r != '0);
  assign q_push    = busy && !q_full;
  assign at_last   = (ptr_r == cnt_r - 1'b1);
  assign last_push = q_push && at_last;
  assign in_ready  = !busy || last_push;
  assign accept    = in_valid && in_ready;

  always_comb begin
    sel     = evts_r[ptr_r];
    stop_c  = (sel.stop < sel.start) ? sel.start : sel.stop;
    q_wdata = '{summ: sel.summ, start: sel.start, stop: stop_c,
                len: sel.summ ? '0 : stop_c - sel.start, last: at_last};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      run_open_r   <= 1'b0;
      open_start_r <= '0;
      free_total_r <= '0;
      cnt_r        <= '0;
      ptr_r        <= '0;
    end else if (accept) begin
      byte_index_r <= byte_index_nxt;
      run_open_r   <= run_open_nxt;
      open_start_r <= open_start_nxt;
      free_total_r <= free_total_nxt;
      cnt_r        <= evt_cnt;
      ptr_r        <= '0;
    end else if (q_push) begin
      if (last_push) begin
        cnt_r <= '0;
      end else begin
        ptr_r <= ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      evts_r <= evts;
    end
  end

endmodule

// ----- src/bfes_queue.sv -----
// ============================================================================
// bfes_queue
// Short register queue between the front and back parts.
// ============================================================================
module bfes_queue import bfes_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  rvalid,
  output qent_t rdata
);

  qent_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_AW:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign rvalid  = (cnt_r != '0);
  assign rdata   = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

// ----- src/bfes_back.sv -----
// ============================================================================
// bfes_back
// Scales queued runs by the block size, keeps the unallocated offset and
// drives the result register.
// ============================================================================
module bfes_back import bfes_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] block_size,
  input  logic              q_valid,
  input  qent_t             q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_summary,
  output logic [BLK_W-1:0]  out_run_start_block,
  output logic [BLK_W-1:0]  out_run_end_block,
  output logic [PROD_W-1:0] out_volume_byte_offset,
  output logic [PROD_W-1:0] out_run_bytes,
  output logic [PROD_W-1:0] out_unalloc_offset,
  output logic [PROD_W-1:0] out_total_free_bytes,
  output logic              out_last_result
);

  logic              m_valid_r, o_valid_r;
  logic              m_summ_r, m_last_r;
  logic [BLK_W-1:0]  m_start_r, m_stop_r;
  logic [PROD_W-1:0] m_prod_a_r, m_prod_b_r;
  logic [OFS_W-1:0]  running_r, running_nxt;
  logic              m_adv;

  assign m_adv = m_valid_r && (!o_valid_r || out_ready);
  assign q_pop = q_valid && (!m_valid_r || m_adv);

  assign running_nxt = m_summ_r ? '0 : running_r + m_prod_b_r[OFS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      running_r <= '0;
    end else begin
      if (q_pop) begin
        m_valid_r <= 1'b1;
      end else if (m_adv) begin
        m_valid_r <= 1'b0;
      end
      if (m_adv) begin
        o_valid_r <= 1'b1;
        running_r <= running_nxt;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_summ_r   <= q_rdata.summ;
      m_last_r   <= q_rdata.last;
      m_start_r  <= q_rdata.start;
      m_stop_r   <= q_rdata.stop;
      m_prod_a_r <= PROD_W'(q_rdata.start) * PROD_W'(block_size);
      m_prod_b_r <= PROD_W'(q_rdata.len) * PROD_W'(block_size);
    end
    if (m_adv) begin
      out_is_summary         <= m_summ_r;
      out_last_result        <= m_last_r;
      out_run_start_block    <= m_summ_r ? '0 : m_start_r;
      out_run_end_block      <= m_summ_r ? '0 : m_stop_r;
      out_volume_byte_offset <= m_summ_r ? '0 : m_prod_a_r;
      out_run_bytes          <= m_summ_r ? '0 : m_prod_b_r;
      out_unalloc_offset     <= m_summ_r ? '0 : PROD_W'(running_r);
      out_total_free_bytes   <= m_summ_r ? m_prod_a_r : '0;
    end
  end

  assign out_valid = o_valid_r;

endmodule

// ----- src/bitmap_free_extent_scanner.sv -----
// ============================================================================
// bitmap_free_extent_scanner
// Finds free runs in a volume allocation bitmap and reports each run with
// its byte offsets, then a summary of the total free bytes.
//
//   channel  direction  beat
//   in_      input      one bitmap byte and its final marker
//   out_     output     one run result or the closing summary
//   cfg_     input      one register write, no wait
//
// A byte with at most one result is taken every cycle. A byte that causes
// more than one result holds the input while the front pushes them, one per
// cycle, into a four-entry queue; the back drains one result per cycle
// through a multiply stage and the output register.
// Reset is synchronous; there is no clearing pass.
// A stalled output fills the queue, which then holds off the input.
// ============================================================================
module bitmap_free_extent_scanner import bfes_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BLK_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_bitmap_byte,
  input  logic              in_final_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_summary,
  output logic [BLK_W-1:0]  out_run_start_block,
  output logic [BLK_W-1:0]  out_run_end_block,
  output logic [PROD_W-1:0] out_volume_byte_offset,
  output logic [PROD_W-1:0] out_run_bytes,
  output logic [PROD_W-1:0] out_unalloc_offset,
  output logic [PROD_W-1:0] out_total_free_bytes,
  output logic              out_last_result
);

  logic [BLK_W-1:0]  block_count_r;
  logic [SIZE_W-1:0] block_size_r;
  logic              q_push, q_full, q_pop, q_valid;
  qent_t             q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
      block_size_r  <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BLOCK_COUNT: block_count_r <= cfg_wdata;
        CFG_BLOCK_SIZE:  block_size_r  <= cfg_wdata[SIZE_W-1:0];
      endcase
    end
  end

  bfes_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .block_count    (block_count_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_bitmap_byte (in_bitmap_byte),
    .in_final_byte  (in_final_byte),
    .q_push         (q_push),
    .q_wdata        (q_wdata),
    .q_full         (q_full)
  );

  bfes_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  bfes_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .block_size             (block_size_r),
    .q_valid                (q_valid),
    .q_rdata                (q_rdata),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_is_summary         (out_is_summary),
    .out_run_start_block    (out_run_start_block),
    .out_run_end_block      (out_run_end_block),
    .out_volume_byte_offset (out_volume_byte_offset),
    .out_run_bytes          (out_run_bytes),
    .out_unalloc_offset     (out_unalloc_offset),
    .out_total_free_bytes   (out_total_free_bytes),
    .out_last_result        (out_last_result)
  );

endmodule

// ----- src/bfes_checker.sv -----
// ============================================================================
// bfes_checker
// Port-level checks on the result channel of the scanner.
// ============================================================================
`include "assert_macros.svh"

module bfes_checker import bfes_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_is_summary,
  input logic [BLK_W-1:0]  out_run_start_block,
  input logic [BLK_W-1:0]  out_run_end_block,
  input logic [PROD_W-1:0] out_run_bytes,
  input logic [PROD_W-1:0] out_unalloc_offset,
  input logic [PROD_W-1:0] out_total_free_bytes,
  input logic              out_last_result
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_run_start_block) && $stable(out_run_bytes) && $stable(out_is_summary) && $stable(out_last_result))

  `ASSERT_IMPLY(a_summary_shape, clk, rst_n, out_valid && out_is_summary, out_last_result && out_run_bytes == '0 && out_unalloc_offset == '0 && out_run_start_block == '0)

  `ASSERT_IMPLY(a_run_shape, clk, rst_n, out_valid && !out_is_summary, out_total_free_bytes == '0 && out_run_end_block >= out_run_start_block)

  `ASSERT_NEXT(a_offset_chain, clk, rst_n, out_valid && out_ready && !out_is_summary, !out_valid || out_is_summary || out_unalloc_offset[OFS_W-1:0] == OFS_W'($past(out_unalloc_offset) + $past(out_run_bytes)))

endmodule

bind bitmap_free_extent_scanner bfes_checker u_bfes_checker (.*);

// ----- tb/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for the bitmap free extent scanner.
// A directed table covers reset state, size and count extremes, bits past
// the block count, short bitmaps and a count lowered under an open run.
// Random volumes follow under several idle and stall patterns. Every output
// beat is compared field by field with an in-bench scan or a table entry.
// ============================================================================
module tb;
  import bfes_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_BYTES    = 36;

  typedef struct packed {
    logic        is_summary;
    logic [31:0] start;
    logic [31:0] stop;
    logic [52:0] vol_ofs;
    logic [52:0] len_bytes;
    logic [52:0] unalloc_ofs;
    logic [52:0] total;
    logic        last;
  } extent_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    idx;
    logic [31:0] value;
    logic        fin;
    logic        typed;
    logic [52:0] total;
  } drill_row_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        cfg_we         = 1'b0;
  cfg_idx_t    cfg_index      = CFG_BLOCK_COUNT;
  logic [31:0] cfg_wdata      = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  in_bitmap_byte = '0;
  logic        in_final_byte  = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic        out_is_summary;
  logic [31:0] out_run_start_block;
  logic [31:0] out_run_end_block;
  logic [52:0] out_volume_byte_offset;
  logic [52:0] out_run_bytes;
  logic [52:0] out_unalloc_offset;
  logic [52:0] out_total_free_bytes;
  logic        out_last_result;

  bitmap_free_extent_scanner dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_bitmap_byte         (in_bitmap_byte),
    .in_final_byte          (in_final_byte),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_is_summary         (out_is_summary),
    .out_run_start_block    (out_run_start_block),
    .out_run_end_block      (out_run_end_block),
    .out_volume_byte_offset (out_volume_byte_offset),
    .out_run_bytes          (out_run_bytes),
    .out_unalloc_offset     (out_unalloc_offset),
    .out_total_free_bytes   (out_total_free_bytes),
    .out_last_result        (out_last_result)
  );

  // scanner state and registers as the bench sees them
  logic [31:0] blk_count = '0;
  logic [20:0] blk_size  = 21'd4096;
  logic [28:0] byte_idx;
  logic        run_open;
  logic [31:0] run_start;
  logic [51:0] unalloc_run;
  logic [31:0] free_blocks;

  extent_t    step_out [MAX_EVT];
  int         step_n;
  extent_t    extent_q [$];
  drill_row_t drill [$];

  int mismatches  = 0;
  int results_seen = 0;
  int runs_seen   = 0;
  int volumes_seen = 0;
  int bytes_sent  = 0;
  int reg_writes  = 0;
  int send_idle   = 0;
  int stall_pct   = 0;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int quiet       = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic clear_volume();
    byte_idx    = '0;
    run_open    = 1'b0;
    run_start   = '0;
    unalloc_run = '0;
    free_blocks = '0;
  endtask

  task automatic close_run(input logic [31:0] stop_blk);
    logic [31:0] stop;
    logic [63:0] len;
    extent_t     e;
    stop = (stop_blk < run_start) ? run_start : stop_blk;
    len  = 64'(stop - run_start) * 64'(blk_size);
    e.is_summary  = 1'b0;
    e.start       = run_start;
    e.stop        = stop;
    e.vol_ofs     = 53'(64'(run_start) * 64'(blk_size));
    e.len_bytes   = len[52:0];
    e.unalloc_ofs = {1'b0, unalloc_run};
    e.total       = '0;
    e.last        = 1'b0;
    unalloc_run   = unalloc_run + len[51:0];
    step_out[step_n] = e;
    step_n++;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic fin);
    logic [31:0] base;
    logic [31:0] blk;
    logic [32:0] stop;
    extent_t     e;
    int          i;
    step_n = 0;
    base   = {byte_idx, 3'b000};
    for (i = 0; i < 8; i++) begin
      blk = base + 32'(i);
      if (blk < blk_count) begin
        if (!b[7-i]) begin
          if (!run_open) begin
            run_open  = 1'b1;
            run_start = blk;
          end
          free_blocks = free_blocks + 32'd1;
        end else if (run_open) begin
          close_run(blk);
          run_open = 1'b0;
        end
      end
    end
    byte_idx = byte_idx + 29'd1;
    if (fin) begin
      if (run_open) begin
        stop = {1'b0, base} + 33'd8;
        if ({1'b0, blk_count} < stop) stop = {1'b0, blk_count};
        close_run(stop[31:0]);
      end
      e = '0;
      e.is_summary = 1'b1;
      e.total      = 53'(64'(free_blocks) * 64'(blk_size));
      step_out[step_n] = e;
      step_n++;
      clear_volume();
    end
    if (step_n > 0) step_out[step_n-1].last = 1'b1;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_BLOCK_COUNT) blk_count = value;
    else blk_size = value[20:0];
    reg_writes++;
  endtask

  task automatic offer_byte(input logic [7:0] b, input logic fin, input logic typed,
                            input logic [52:0] typed_total);
    extent_t e;
    int      k;
    in_valid       <= 1'b1;
    in_bitmap_byte <= b;
    in_final_byte  <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_byte(b, fin);
    if (typed) begin
      e = '0;
      e.is_summary = 1'b1;
      e.total      = typed_total;
      e.last       = 1'b1;
      extent_q.push_back(e);
    end else begin
      for (k = 0; k < step_n; k++) extent_q.push_back(step_out[k]);
    end
    bytes_sent++;
  endtask

  // drop valid and wait out every pending result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (extent_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic gap();
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    if ($urandom_range(0, 29) == 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (extent_q.size() != 0) @(posedge clk);
    end
  endtask

  task automatic cfg_row(input cfg_idx_t idx, input logic [31:0] value);
    drill_row_t r;
    r = '{kind: ROW_CFG, idx: idx, value: value, fin: 1'b0, typed: 1'b0, total: '0};
    drill.push_back(r);
  endtask

  task automatic byte_row(input logic [7:0] b, input logic fin, input logic typed,
                          input logic [52:0] total);
    drill_row_t r;
    r = '{kind: ROW_BYTE, idx: CFG_BLOCK_COUNT, value: {24'd0, b}, fin: fin,
          typed: typed, total: total};
    drill.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // receiver: random stall, or a long hold on request
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    extent_t got;
    extent_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{is_summary: out_is_summary, start: out_run_start_block,
              stop: out_run_end_block, vol_ofs: out_volume_byte_offset,
              len_bytes: out_run_bytes, unalloc_ofs: out_unalloc_offset,
              total: out_total_free_bytes, last: out_last_result};
      results_seen++;
      if (got.is_summary) volumes_seen++;
      else runs_seen++;
      if (extent_q.size() == 0) begin
        report_mismatch("result beat with no pending expectation");
      end else begin
        want = extent_q.pop_front();
        check_field("is_summary", 64'(got.is_summary), 64'(want.is_summary));
        check_field("run_start_block", 64'(got.start), 64'(want.start));
        check_field("run_end_block", 64'(got.stop), 64'(want.stop));
        check_field("volume_byte_offset", 64'(got.vol_ofs), 64'(want.vol_ofs));
        check_field("run_bytes", 64'(got.len_bytes), 64'(want.len_bytes));
        check_field("unalloc_offset", 64'(got.unalloc_ofs), 64'(want.unalloc_ofs));
        check_field("total_free_bytes", 64'(got.total), 64'(want.total));
        check_field("last_result", 64'(got.last), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet < WATCHDOG_LIMIT) begin
      quiet <= quiet + 1;
    end else begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, extent_q.size());
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    drill_row_t  r;
    logic [7:0]  b;
    logic        fin;
    logic [31:0] count;
    logic [31:0] bsize;
    int          p;
    int          n;
    int          len;
    int          j;

    clear_volume();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    byte_row(8'h00, 1'b1, 1'b1, 53'd0);
    cfg_row(CFG_BLOCK_COUNT, 32'd16);
    cfg_row(CFG_BLOCK_SIZE, 32'd512);
    byte_row(8'hFF, 1'b1, 1'b1, 53'd0);
    byte_row(8'h00, 1'b0, 1'b0, '0);
    byte_row(8'hFF, 1'b1, 1'b0, '0);
    byte_row(8'h54, 1'b0, 1'b0, '0);
    byte_row(8'hAA, 1'b1, 1'b0, '0);
    byte_row(8'h00, 1'b0, 1'b0, '0);
    byte_row(8'h00, 1'b0, 1'b0, '0);
    byte_row(8'hFF, 1'b1, 1'b0, '0);
    cfg_row(CFG_BLOCK_COUNT, 32'd100);
    byte_row(8'hF0, 1'b1, 1'b0, '0);
    byte_row(8'hF0, 1'b0, 1'b0, '0);
    cfg_row(CFG_BLOCK_COUNT, 32'd2);
    byte_row(8'h00, 1'b1, 1'b0, '0);
    cfg_row(CFG_BLOCK_COUNT, 32'hFFFF_FFFF);
    cfg_row(CFG_BLOCK_SIZE, 32'd1048576);
    byte_row(8'h00, 1'b1, 1'b0, '0);
    byte_row(8'h81, 1'b1, 1'b0, '0);
    cfg_row(CFG_BLOCK_SIZE, 32'h001F_FFFF);
    byte_row(8'h3C, 1'b1, 1'b0, '0);
    cfg_row(CFG_BLOCK_SIZE, 32'd0);
    byte_row(8'h0F, 1'b1, 1'b0, '0);
    cfg_row(CFG_BLOCK_SIZE, 32'hFFE0_0200);
    cfg_row(CFG_BLOCK_COUNT, 32'd16);
    byte_row(8'hFF, 1'b0, 1'b0, '0);
    byte_row(8'hFF, 1'b1, 1'b1, 53'd0);

    send_idle = 20;
    stall_pct <= 20;
    foreach (drill[i]) begin
      r = drill[i];
      if (r.kind == ROW_CFG) begin
        settle();
        write_reg(r.idx, r.value);
      end else begin
        offer_byte(r.value[7:0], r.fin, r.typed, r.total);
        gap();
      end
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      case ($urandom_range(0, 5))
        0: count = 32'd0;
        1: count = $urandom_range(1, 40);
        2: count = $urandom_range(8, 120);
        3: count = 8 * $urandom_range(1, 12);
        4: count = 32'hFFFF_FFFF;
        default: count = $urandom;
      endcase
      if (p == 0) count = 32'hFFFF_FFFF;
      case ($urandom_range(0, 4))
        0: bsize = 32'd512;
        1: bsize = 32'd1048576;
        2: bsize = $urandom_range(512, 1048576);
        3: bsize = $urandom;
        default: bsize = $urandom_range(512, 8192);
      endcase
      write_reg(CFG_BLOCK_COUNT, count);
      write_reg(CFG_BLOCK_SIZE, bsize);
      case (p % 4)
        0: begin send_idle = 0;  stall_pct <= 0;  end
        1: begin send_idle = 60; stall_pct <= 0;  end
        2: begin send_idle = 0;  stall_pct <= 60; end
        default: begin send_idle = 23; stall_pct <= 23; end
      endcase
      if (p == 0) hold_reqs <= hold_reqs + 1;
      n = 0;
      while (n < PHASE_BYTES) begin
        len = $urandom_range(1, 12);
        for (j = 0; j < len; j++) begin
          case ($urandom_range(0, 9))
            0, 1: b = 8'h00;
            2: b = 8'hFF;
            3: b = $urandom_range(0, 1) ? 8'h55 : 8'hAA;
            default: b = 8'($urandom);
          endcase
          fin = (j == len - 1);
          if ($urandom_range(0, 14) == 0) fin = ~fin;
          offer_byte(b, fin, 1'b0, '0);
          n++;
          gap();
        end
      end
    end

    settle();
    $display("covered %0d bitmap bytes: %0d free runs and %0d volume summaries checked",
             bytes_sent, runs_seen, volumes_seen);
    $display("%0d register writes over zero, odd, minimum and maximum settings", reg_writes);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
